/* hdl/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants of the FAT16 cluster chain engine: operation,
// status and result codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int CLUSTER_W = 16;
    localparam int CNT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int LIMIT_W   = 17;

    localparam logic [CLUSTER_W-1:0] END_MARK      = 16'hFFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 16'd2;
    localparam logic [CFG_W-1:0]     CFG_RESET     = 13'd4096;

    localparam logic [1:0] OP_FOLLOW = 2'd0;
    localparam logic [1:0] OP_LINK   = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_ALLOC  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BEYOND  = 2'd2;
    localparam logic [1:0] ST_NOSPACE = 2'd3;

    // result selects for the pending result register
    localparam logic [2:0] RES_CHECK   = 3'd0;
    localparam logic [2:0] RES_DONE    = 3'd1;
    localparam logic [2:0] RES_DATA    = 3'd2;
    localparam logic [2:0] RES_HEAD    = 3'd3;
    localparam logic [2:0] RES_NOSPACE = 3'd4;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       rd_cur;
        logic       wr_link;
        logic       free_ev;
        logic       scan_init;
        logic       scan_ev;
        logic       term;
        logic       fail_walk;
        logic       set_res;
        logic [2:0] res_sel;
        logic       post;
    } cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       cur_ok;
        logic       scan_more;
        logic       alloc_ok;
        logic       out_free;
        logic [1:0] op;
    } sts_t;

endpackage

/* hdl/fcc_ram.sv */
// ----------------------------------------------------------------------------
// fcc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/fcc_datapath.sv */
// ----------------------------------------------------------------------------
// fcc_datapath
// Link table memory, cluster walk and scan registers, table size register,
// pending result and output word register.
// ----------------------------------------------------------------------------
module fcc_datapath #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcc_pkg::cmd_t                 cmd,
    output fcc_pkg::sts_t                 sts,
    input  logic [1:0]                    in_operation,
    input  logic [fcc_pkg::CLUSTER_W-1:0] in_cluster,
    input  logic [fcc_pkg::CLUSTER_W-1:0] in_link_value,
    input  logic [fcc_pkg::CNT_W-1:0]     in_alloc_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fcc_pkg::CFG_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [fcc_pkg::CLUSTER_W-1:0] out_cluster
);

    import fcc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam logic [LIMIT_W-1:0] TABLE_LIM = LIMIT_W'(TABLE_ENTRIES);
    localparam logic [ADDR_W:0]    CLR_END   = (ADDR_W + 1)'(TABLE_ENTRIES);

    function automatic logic cl_valid(input logic [LIMIT_W-1:0] c);
        return (c >= LIMIT_W'(FIRST_CLUSTER)) && (c < LIMIT_W'(END_MARK));
    endfunction

    logic [CFG_W-1:0]     limit_reg, limit_next;
    logic [1:0]           op_reg, op_next;
    logic [LIMIT_W-1:0]   cur_reg, cur_next;
    logic [CLUSTER_W-1:0] lv_reg, lv_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CLUSTER_W-1:0] head_reg, head_next;
    logic [CLUSTER_W-1:0] prev_reg, prev_next;
    logic [ADDR_W:0]      clr_reg, clr_next;
    logic [1:0]           res_st_reg, res_st_next;
    logic [CLUSTER_W-1:0] res_cl_reg, res_cl_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_st_reg, out_st_next;
    logic [CLUSTER_W-1:0] out_cl_reg, out_cl_next;

    logic [LIMIT_W-1:0]   lim;
    logic [1:0]           cur_chk;
    logic                 head_valid;
    logic                 prev_valid;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [CLUSTER_W-1:0] wr_data;
    logic [CLUSTER_W-1:0] rd_data;

    assign lim = (LIMIT_W'(limit_reg) < TABLE_LIM) ? LIMIT_W'(limit_reg) : TABLE_LIM;

    always_comb
    begin
        if (!cl_valid(cur_reg))
            cur_chk = ST_INVALID;
        else if (cur_reg >= lim)
            cur_chk = ST_BEYOND;
        else
            cur_chk = ST_OK;
    end

    assign head_valid = cl_valid(LIMIT_W'(head_reg));
    assign prev_valid = cl_valid(LIMIT_W'(prev_reg));

    // table writes: one source per controller state
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_reg[ADDR_W-1:0];
        wr_data = '0;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[ADDR_W-1:0];
        end
        else if (cmd.wr_link)
        begin
            wr_en   = 1'b1;
            wr_data = lv_reg;
        end
        else if (cmd.free_ev)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.scan_ev)
        begin
            // chain the previous free entry to this one
            wr_en   = (rd_data == '0) && prev_valid;
            wr_addr = prev_reg[ADDR_W-1:0];
            wr_data = cur_reg[CLUSTER_W-1:0];
        end
        else if (cmd.term)
        begin
            wr_en   = 1'b1;
            wr_addr = prev_reg[ADDR_W-1:0];
            wr_data = END_MARK;
        end
    end

    always_comb
    begin
        limit_next     = limit_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        lv_next        = lv_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        prev_next      = prev_reg;
        clr_next       = clr_reg;
        res_st_next    = res_st_reg;
        res_cl_next    = res_cl_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_cl_next    = out_cl_reg;

        if (cfg_valid)
            limit_next = cfg_data;

        if (cmd.load)
        begin
            op_next  = in_operation;
            cur_next = LIMIT_W'(in_cluster);
            lv_next  = in_link_value;
            cnt_next = in_alloc_count;
        end

        if (cmd.clr_step)
            clr_next = clr_reg + 1'b1;

        if (cmd.scan_init)
        begin
            cur_next  = LIMIT_W'(FIRST_CLUSTER);
            head_next = END_MARK;
            prev_next = END_MARK;
        end

        if (cmd.scan_ev)
        begin
            if (rd_data == '0)
            begin
                if (!head_valid)
                    head_next = cur_reg[CLUSTER_W-1:0];
                prev_next = cur_reg[CLUSTER_W-1:0];
                cnt_next  = cnt_reg - 1'b1;
            end
            cur_next = cur_reg + 1'b1;
        end

        if (cmd.free_ev)
            cur_next = LIMIT_W'(rd_data);

        // give back a partial chain starting at its head
        if (cmd.fail_walk)
            cur_next = LIMIT_W'(head_reg);

        if (cmd.set_res)
        begin
            case (cmd.res_sel)
                RES_CHECK:
                begin
                    res_st_next = cur_chk;
                    res_cl_next = END_MARK;
                end
                RES_DONE:
                begin
                    res_st_next = ST_OK;
                    res_cl_next = '0;
                end
                RES_DATA:
                begin
                    res_st_next = ST_OK;
                    res_cl_next = rd_data;
                end
                RES_HEAD:
                begin
                    res_st_next = ST_OK;
                    res_cl_next = head_reg;
                end
                default:
                begin
                    res_st_next = ST_NOSPACE;
                    res_cl_next = END_MARK;
                end
            endcase
        end

        if (cmd.post)
        begin
            out_valid_next = 1'b1;
            out_st_next    = res_st_reg;
            out_cl_next    = res_cl_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= CFG_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cur_reg    <= cur_next;
        lv_reg     <= lv_next;
        cnt_reg    <= cnt_next;
        head_reg   <= head_next;
        prev_reg   <= prev_next;
        res_st_reg <= res_st_next;
        res_cl_reg <= res_cl_next;
        out_st_reg <= out_st_next;
        out_cl_reg <= out_cl_next;
    end

    fcc_ram #(
        .WIDTH (CLUSTER_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_cur),
        .rd_addr (cur_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign sts.clr_done  = (clr_reg == CLR_END);
    assign sts.cur_ok    = (cur_chk == ST_OK);
    assign sts.scan_more = (cur_reg < lim) && (cnt_reg != '0);
    assign sts.alloc_ok  = (cnt_reg == '0) && prev_valid;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.op        = op_reg;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_status  = out_st_reg;
    assign out_cluster = out_cl_reg;

endmodule

/* hdl/fcc_ctrl.sv */
// ----------------------------------------------------------------------------
// fcc_ctrl
// Sequencer of the cluster chain engine: clearing pass, operation dispatch,
// free walk, first-fit scan and result posting.
// ----------------------------------------------------------------------------
module fcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fcc_pkg::sts_t sts,
    output fcc_pkg::cmd_t cmd
);

    import fcc_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DISPATCH  = 4'd2;
    localparam logic [3:0] S_FOLLOW_EV = 4'd3;
    localparam logic [3:0] S_FREE_RD   = 4'd4;
    localparam logic [3:0] S_FREE_EV   = 4'd5;
    localparam logic [3:0] S_SCAN_RD   = 4'd6;
    localparam logic [3:0] S_SCAN_EV   = 4'd7;
    localparam logic [3:0] S_SCAN_END  = 4'd8;
    localparam logic [3:0] S_POST      = 4'd9;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = S_IDLE;
                else
                    cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_FOLLOW:
                    begin
                        if (sts.cur_ok)
                        begin
                            cmd.rd_cur = 1'b1;
                            state_next = S_FOLLOW_EV;
                        end
                        else
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res_sel = RES_CHECK;
                            state_next  = S_POST;
                        end
                    end
                    OP_LINK:
                    begin
                        cmd.wr_link = sts.cur_ok;
                        cmd.set_res = 1'b1;
                        cmd.res_sel = sts.cur_ok ? RES_DONE : RES_CHECK;
                        state_next  = S_POST;
                    end
                    OP_FREE:
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = sts.cur_ok ? RES_DONE : RES_CHECK;
                        state_next  = sts.cur_ok ? S_FREE_RD : S_POST;
                    end
                    default:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                endcase
            end
            S_FOLLOW_EV:
            begin
                cmd.set_res = 1'b1;
                cmd.res_sel = RES_DATA;
                state_next  = S_POST;
            end
            S_FREE_RD:
            begin
                // stop at the first successor that is not a usable cluster
                if (sts.cur_ok)
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_FREE_EV;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_FREE_EV:
            begin
                cmd.free_ev = 1'b1;
                state_next  = S_FREE_RD;
            end
            S_SCAN_RD:
            begin
                if (sts.scan_more)
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_SCAN_EV;
                end
                else
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_EV:
            begin
                cmd.scan_ev = 1'b1;
                state_next  = S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                cmd.set_res = 1'b1;
                if (sts.alloc_ok)
                begin
                    cmd.term    = 1'b1;
                    cmd.res_sel = RES_HEAD;
                    state_next  = S_POST;
                end
                else
                begin
                    cmd.fail_walk = 1'b1;
                    cmd.res_sel   = RES_NOSPACE;
                    state_next    = S_FREE_RD;
                end
            end
            S_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

/* hdl/fat_cluster_chain_engine.sv */
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine
// Link and rejected clusters are answered from the dispatch state, follow
// reads one entry, free walks the chain entry by entry, and allocate scans
// first-fit and gives back the partial chain when space runs short. One item at a time.
// After reset a clearing pass zeroes the table through its single write port;
// s_axis_tready stays low until it ends.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // cluster[15:0], link_value[31:16], alloc_count[44:32]
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // result_cluster[15:0]
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data       // clusters_in_table
);

    import fcc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fcc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_operation   (s_axis_tuser),
        .in_cluster     (s_axis_tdata[15:0]),
        .in_link_value  (s_axis_tdata[31:16]),
        .in_alloc_count (s_axis_tdata[44:32]),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (m_axis_tuser),
        .out_cluster    (m_axis_tdata)
    );

endmodule

/* hdl/fcc_checker.sv */
// ----------------------------------------------------------------------------
// fcc_checker
// Port-level checks of the cluster chain engine, bound to the top level.
// ----------------------------------------------------------------------------
module fcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    import fcc_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // any failure carries the end marker
    a_fail_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == END_MARK)
        else $error("failed result without end marker");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    // clearing pass follows reset
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("ready or result right after reset");

endmodule

bind fat_cluster_chain_engine fcc_checker u_fcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
